FILE: design/ppp_pkg.sv
// ----------------------------------------------------------------------------
// ppp_pkg: shared types and constants of the paged two-plane pixel plotter
// Panel geometry, plane memory size, request and register codes.
// ----------------------------------------------------------------------------
package ppp_pkg;

    localparam int PANEL_COLS    = 128;
    localparam int PANEL_LINES   = 250;
    localparam int MAX_PAGE_ROWS = 64;

    localparam int PLANE_DEPTH   = 1024;
    localparam int ADDR_W        = $clog2(PLANE_DEPTH);
    localparam int FILL_W        = ADDR_W + 1;
    localparam int BYTES_PER_ROW = PANEL_COLS / 8;
    localparam int COORD_W       = 16;
    localparam int TOP_W         = 16;
    localparam int ROWS_W        = 7;

    typedef enum logic [1:0] {
        REQ_DRAW = 2'd0,
        REQ_PAGE = 2'd1,
        REQ_READ = 2'd2,
        REQ_NONE = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        CFG_ROTATION  = 3'd0,
        CFG_FLIP_MODE = 3'd1,
        CFG_PAGE_ROWS = 3'd2,
        CFG_DRAW_W    = 3'd3,
        CFG_DRAW_H    = 3'd4,
        CFG_DEF_COLOR = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]        rotation;
        logic [1:0]        flip_mode;
        logic [ROWS_W-1:0] rows;
        logic [7:0]        draw_w;
        logic [7:0]        draw_h;
        logic [TOP_W-1:0]  top_row;
    } t_geom;

    typedef struct packed {
        logic              hit;
        logic [ADDR_W-1:0] addr;
        logic [2:0]        bit_sel;
    } t_hit;

endpackage

FILE: design/ppp_ram.sv
// ----------------------------------------------------------------------------
// ppp_ram: simple dual-port synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module ppp_ram #(
    parameter int ADDR_W = 10,
    parameter int DATA_W = 16
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/ppp_xform.sv
// ----------------------------------------------------------------------------
// ppp_xform: pixel coordinate transform and page hit check
// Stage one mirrors and rotates the pixel; stage two checks the page bounds
// and forms the plane byte address and bit select.
// ----------------------------------------------------------------------------
module ppp_xform
    import ppp_pkg::*;
(
    input  logic               i_clk,
    input  t_geom              i_geom,
    input  logic signed [10:0] i_x,
    input  logic signed [10:0] i_y,
    output t_hit               o_hit
);

    localparam logic signed [COORD_W-1:0] ROT_XOFF = COORD_W'(PANEL_COLS - 7);
    localparam logic signed [COORD_W-1:0] ROT_YOFF = COORD_W'(PANEL_LINES - 1);
    localparam int DY_W = TOP_W + 2;

    logic signed [COORD_W-1:0] sx, sy, dw, dh, fx, fy, n_x1, n_y1;
    logic signed [COORD_W-1:0] r_x1, r_y1;
    logic signed [DY_W-1:0]    dy;
    logic                      in_y, in_x;
    logic [ROWS_W-1:0]         row;
    logic [COORD_W-1:0]        addr_full;
    t_hit                      n_hit, r_hit;

    always_comb begin
        sx = COORD_W'(i_x);
        sy = COORD_W'(i_y);
        dw = $signed({{(COORD_W-8){1'b0}}, i_geom.draw_w});
        dh = $signed({{(COORD_W-8){1'b0}}, i_geom.draw_h});
        fx = i_geom.flip_mode[0] ? dw - sx : sx;
        fy = i_geom.flip_mode[1] ? dh - sy : sy;
        case (i_geom.rotation)
            2'd0: begin
                n_x1 = fx;
                n_y1 = fy;
            end
            2'd1: begin
                n_x1 = ROT_XOFF - fy;
                n_y1 = fx;
            end
            2'd2: begin
                n_x1 = ROT_XOFF - fx;
                n_y1 = ROT_YOFF - fy;
            end
            default: begin
                n_x1 = fy;
                n_y1 = ROT_YOFF - fx;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_x1 <= n_x1;
        r_y1 <= n_y1;
    end

    always_comb begin
        dy   = $signed({{(DY_W-COORD_W){r_y1[COORD_W-1]}}, r_y1})
             - $signed({2'b00, i_geom.top_row});
        in_y = !dy[DY_W-1] && (dy < $signed({{(DY_W-ROWS_W){1'b0}}, i_geom.rows}));
        in_x = !r_x1[COORD_W-1]
            && (r_x1 < $signed({{(COORD_W-8){1'b0}}, i_geom.draw_w}));
        row  = i_geom.rows - ROWS_W'(1) - dy[ROWS_W-1:0];
        addr_full = COORD_W'(row) * COORD_W'(BYTES_PER_ROW)
                  + {3'b000, r_x1[COORD_W-1:3]};
        n_hit.hit     = in_y && in_x && (addr_full < COORD_W'(PLANE_DEPTH));
        n_hit.addr    = addr_full[ADDR_W-1:0];
        n_hit.bit_sel = r_x1[2:0];
    end

    always_ff @(posedge i_clk) begin
        r_hit <= n_hit;
    end

    assign o_hit = r_hit;

endmodule

FILE: design/paged_two_plane_pixel_plotter.sv
// ----------------------------------------------------------------------------
// paged_two_plane_pixel_plotter: one page of a two-plane e-paper frame
//
// Channel  Dir  Handshake                     Content
// s_axis   in   s_axis_tvalid/s_axis_tready   tuser request, tdata pixel/page/read
// m_axis   out  m_axis_tvalid/m_axis_tready   tdata black, red, pixel stored
// cfg      in   i_cfg_we                      i_cfg_idx, i_cfg_data
//
// A draw that lands in the page passes two transform stages, a plane read, a write
// back and the result slot before the block is idle for the next item; a miss skips
// the write back. A read passes a plane read and the result slot, an unused request
// only the slot. A begin-page item fills page rows * 16 bytes, one plane byte per cycle.
// Reset clears control state and configuration; the planes are not cleared.
// A stalled result waits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
module paged_two_plane_pixel_plotter
    import ppp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // pixel_x, pixel_y, color, page_index, byte_address
    input  logic [1:0]  s_axis_tuser,  // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // black plane byte, red plane byte, pixel_stored
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_XFA   = 8'b0000_0010,
        S_XFB   = 8'b0000_0100,
        S_RMWRD = 8'b0000_1000,
        S_RMWWR = 8'b0001_0000,
        S_FILL  = 8'b0010_0000,
        S_RDDAT = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    logic [1:0]        r_rotation, r_flip_mode, r_def_color;
    logic [ROWS_W-1:0] r_page_rows;
    logic [7:0]        r_draw_w, r_draw_h;
    logic [TOP_W-1:0]  r_top_row, n_top_row;

    logic signed [10:0] r_px, r_py;
    logic [1:0]         r_color;

    logic [FILL_W-1:0] r_fill_cnt, n_fill_cnt, r_fill_len, n_fill_len;
    logic [ROWS_W-1:0] rows_eff;
    logic [15:0]       fill_prod;

    logic [16:0] r_res, n_res;
    logic        r_out_valid, n_out_valid;
    logic [16:0] r_out_data;

    t_geom             geom;
    t_hit              hit;
    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [15:0]       ram_wdata, ram_rdata;
    logic [7:0]        new_b, new_r;
    logic [2:0]        bit_pos;
    logic              accept, out_free;

    assign rows_eff  = (int'(r_page_rows) > MAX_PAGE_ROWS) ? ROWS_W'(MAX_PAGE_ROWS)
                                                           : r_page_rows;
    assign fill_prod = 16'(rows_eff) * 16'(BYTES_PER_ROW);
    assign n_fill_len = (fill_prod > 16'(PLANE_DEPTH)) ? FILL_W'(PLANE_DEPTH)
                                                       : fill_prod[FILL_W-1:0];
    assign n_top_row = TOP_W'(16'(s_axis_tdata[31:24]) * 16'(rows_eff));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rotation  <= 2'd0;
            r_flip_mode <= 2'd0;
            r_page_rows <= ROWS_W'(50);
            r_draw_w    <= 8'd128;
            r_draw_h    <= 8'd250;
            r_def_color <= 2'd1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ROTATION:  r_rotation  <= i_cfg_data[1:0];
                CFG_FLIP_MODE: r_flip_mode <= i_cfg_data[1:0];
                CFG_PAGE_ROWS: r_page_rows <= i_cfg_data[ROWS_W-1:0];
                CFG_DRAW_W:    r_draw_w    <= i_cfg_data;
                CFG_DRAW_H:    r_draw_h    <= i_cfg_data;
                CFG_DEF_COLOR: r_def_color <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_px    <= s_axis_tdata[10:0];
            r_py    <= s_axis_tdata[21:11];
            r_color <= s_axis_tdata[23:22];
        end
    end

    assign geom.rotation  = r_rotation;
    assign geom.flip_mode = r_flip_mode;
    assign geom.rows      = rows_eff;
    assign geom.draw_w    = r_draw_w;
    assign geom.draw_h    = r_draw_h;
    assign geom.top_row   = r_top_row;

    ppp_xform u_xform (
        .i_clk (i_clk),
        .i_geom(geom),
        .i_x   (r_px),
        .i_y   (r_py),
        .o_hit (hit)
    );

    assign bit_pos = 3'd7 - hit.bit_sel;

    always_comb begin
        new_b = ram_rdata[7:0];
        new_r = ram_rdata[15:8];
        new_b[bit_pos] = r_color[0];
        new_r[bit_pos] = r_color[1];
    end

    always_comb begin
        n_state     = r_state;
        n_fill_cnt  = r_fill_cnt;
        n_res       = r_res;
        n_out_valid = r_out_valid && !m_axis_tready;
        ram_we      = 1'b0;
        ram_waddr   = hit.addr;
        ram_wdata   = {new_r, new_b};
        ram_re      = 1'b0;
        ram_raddr   = hit.addr;
        unique case (r_state)
            S_IDLE: begin
                n_fill_cnt = '0;
                n_res      = '0;
                if (accept) begin
                    unique case (t_req'(s_axis_tuser))
                        REQ_DRAW: n_state = S_XFA;
                        REQ_PAGE: n_state = S_FILL;
                        REQ_READ: begin
                            ram_re    = 1'b1;
                            ram_raddr = s_axis_tdata[41:32];
                            n_state   = S_RDDAT;
                        end
                        default:  n_state = S_OUT;
                    endcase
                end
            end
            S_XFA: n_state = S_XFB;
            S_XFB: n_state = S_RMWRD;
            S_RMWRD: begin
                if (hit.hit) begin
                    ram_re  = 1'b1;
                    n_state = S_RMWWR;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_RMWWR: begin
                ram_we  = 1'b1;
                n_res   = 17'h1_0000;
                n_state = S_OUT;
            end
            S_FILL: begin
                if (r_fill_cnt < r_fill_len) begin
                    ram_we     = 1'b1;
                    ram_waddr  = r_fill_cnt[ADDR_W-1:0];
                    ram_wdata  = {{8{r_def_color[1]}}, {8{r_def_color[0]}}};
                    n_fill_cnt = r_fill_cnt + FILL_W'(1);
                end else begin
                    n_state = S_OUT;
                end
            end
            S_RDDAT: begin
                n_res   = {1'b0, ram_rdata};
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    ppp_ram #(
        .ADDR_W(ADDR_W),
        .DATA_W(16)
    ) u_planes (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_top_row   <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (accept && (t_req'(s_axis_tuser) == REQ_PAGE)) begin
                r_top_row <= n_top_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fill_cnt <= n_fill_cnt;
        r_res      <= n_res;
        if (accept) begin
            r_fill_len <= n_fill_len;
        end
        if (r_state == S_OUT && out_free) begin
            r_out_data <= r_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_out_data};

    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_RMWWR || r_state == S_FILL))
        else $error("plane write outside write-back or fill");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && r_state == S_FILL) |-> (r_fill_cnt < r_fill_len))
        else $error("page fill ran past its length");

    a_stored_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[16]) |-> (m_axis_tdata[15:0] == 16'h0))
        else $error("drawn pixel result carries plane bytes");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_state != S_IDLE))
        else $error("accepted item did not start");

endmodule

FILE: test/tb_paged_two_plane_pixel_plotter.sv
// ----------------------------------------------------------------------------
// tb_paged_two_plane_pixel_plotter: self-checking bench for the page plotter
// A short scripted sequence walks the request types, the page and address
// edges and the register extremes. Random phases then follow, each with a
// fresh register setting, mostly aimed draws that land in the current page.
// Every result item is compared with a scripted value or a predictor that mirrors both planes.
// ----------------------------------------------------------------------------
module tb_paged_two_plane_pixel_plotter
    import ppp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RUN_LIMIT    = 4_000_000;
    localparam int PHASES       = 16;
    localparam int PHASE_ITEMS  = 50;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        t_req               req;
        logic signed [10:0] x;
        logic signed [10:0] y;
        logic [1:0]         color;
        logic [7:0]         page;
        logic [9:0]         addr;
    } t_pix_req;

    typedef struct {
        logic [7:0] black;
        logic [7:0] red;
        logic       stored;
    } t_plane_res;

    typedef struct {
        bit         is_cfg;
        t_cfg_idx   cfg_idx;
        logic [7:0] cfg_val;
        t_pix_req   item;
        bit         typed;
        t_plane_res res;
    } t_script_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;  // pixel_x, pixel_y, color, page_index, byte_address
    logic [1:0]  s_axis_tuser;  // req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;  // black plane byte, red plane byte, pixel_stored
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [7:0]  i_cfg_data;

    paged_two_plane_pixel_plotter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    logic [7:0] black_mem [PLANE_DEPTH];
    logic [7:0] red_mem [PLANE_DEPTH];
    int         top_row;
    logic [1:0] rot_cfg;
    logic [1:0] flip_cfg;
    logic [6:0] rows_cfg;
    logic [7:0] width_cfg;
    logic [7:0] height_cfg;
    logic [1:0] fill_cfg;

    t_plane_res  expected_q[$];
    t_script_row script[$];
    int          mismatches = 0;
    int          cycle_count = 0;
    bit          calm;

    function automatic int eff_rows();
        return (int'(rows_cfg) > MAX_PAGE_ROWS) ? MAX_PAGE_ROWS : int'(rows_cfg);
    endfunction

    function automatic t_plane_res plot_step(t_pix_req it);
        t_plane_res r;
        int rows, px, py, qx, qy, where, bitn, count;
        r.black  = 8'h00;
        r.red    = 8'h00;
        r.stored = 1'b0;
        rows = eff_rows();
        case (it.req)
            REQ_DRAW: begin
                px = int'(it.x);
                py = int'(it.y);
                if (flip_cfg[0]) px = int'(width_cfg) - px;
                if (flip_cfg[1]) py = int'(height_cfg) - py;
                case (rot_cfg)
                    2'd0: begin qx = px; qy = py; end
                    2'd1: begin qx = PANEL_COLS - py - 7; qy = px; end
                    2'd2: begin qx = PANEL_COLS - px - 7; qy = PANEL_LINES - 1 - py; end
                    default: begin qx = py; qy = PANEL_LINES - 1 - px; end
                endcase
                if (rows > 0 && qy >= top_row && qy <= top_row + rows - 1 &&
                    qx >= 0 && qx <= int'(width_cfg) - 1) begin
                    where = (rows - 1 - (qy - top_row)) * BYTES_PER_ROW + qx / 8;
                    if (where >= 0 && where < PLANE_DEPTH) begin
                        bitn = 7 - qx % 8;
                        black_mem[where][bitn] = it.color[0];
                        red_mem[where][bitn]   = it.color[1];
                        r.stored = 1'b1;
                    end
                end
            end
            REQ_PAGE: begin
                count = BYTES_PER_ROW * rows;
                if (count > PLANE_DEPTH) count = PLANE_DEPTH;
                top_row = (int'(it.page) * rows) & 16'hFFFF;
                for (int a = 0; a < count; a++) begin
                    black_mem[a] = fill_cfg[0] ? 8'hFF : 8'h00;
                    red_mem[a]   = fill_cfg[1] ? 8'hFF : 8'h00;
                end
            end
            REQ_READ: begin
                r.black = black_mem[it.addr];
                r.red   = red_mem[it.addr];
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic void add_row(t_req req, int x, int y, int color, int page, int addr,
                                    bit typed, int blk, int rd, int st);
        t_script_row row;
        row.is_cfg     = 1'b0;
        row.cfg_idx    = CFG_ROTATION;
        row.cfg_val    = 8'h00;
        row.item.req   = req;
        row.item.x     = x[10:0];
        row.item.y     = y[10:0];
        row.item.color = color[1:0];
        row.item.page  = page[7:0];
        row.item.addr  = addr[9:0];
        row.typed      = typed;
        row.res.black  = blk[7:0];
        row.res.red    = rd[7:0];
        row.res.stored = st[0];
        script.push_back(row);
    endfunction

    function automatic void add_cfg(t_cfg_idx idx, int val);
        t_script_row row;
        row.is_cfg  = 1'b1;
        row.cfg_idx = idx;
        row.cfg_val = val[7:0];
        row.typed   = 1'b0;
        script.push_back(row);
    endfunction

    task automatic note_mismatch(string what, logic [23:0] want, logic [23:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("Mismatch on %s: expected %0h, got %0h", what, want, got);
    endtask

    task automatic send_item(t_pix_req it, t_plane_res res);
        if (!calm && $urandom_range(99) < 10) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(3)) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.req;
        s_axis_tdata  <= {6'b0, it.addr, it.page, it.color, it.y, it.x};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_q.push_back(res);
    endtask

    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [7:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_ROTATION:  rot_cfg    = val[1:0];
            CFG_FLIP_MODE: flip_cfg   = val[1:0];
            CFG_PAGE_ROWS: rows_cfg   = val[6:0];
            CFG_DRAW_W:    width_cfg  = val;
            CFG_DRAW_H:    height_cfg = val;
            CFG_DEF_COLOR: fill_cfg   = val[1:0];
            default: begin
            end
        endcase
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        m_axis_tready <= calm || ($urandom_range(99) >= 10);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_plane_res want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_q.size() == 0) begin
                note_mismatch("unexpected result item", 24'h0, m_axis_tdata);
            end else begin
                want = expected_q.pop_front();
                if (m_axis_tdata[7:0] !== want.black)
                    note_mismatch("black plane byte", 24'(want.black),
                                  24'(m_axis_tdata[7:0]));
                if (m_axis_tdata[15:8] !== want.red)
                    note_mismatch("red plane byte", 24'(want.red),
                                  24'(m_axis_tdata[15:8]));
                if (m_axis_tdata[16] !== want.stored)
                    note_mismatch("pixel_stored", 24'(want.stored),
                                  24'(m_axis_tdata[16]));
            end
        end
    end

    initial begin
        t_pix_req it;
        int ph, k, v, roll, rows, dw, px, py, qx, qy;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = REQ_DRAW;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_ROTATION;
        i_cfg_data    = 8'h00;
        calm          = 1'b0;
        top_row       = 0;
        rot_cfg       = 2'd0;
        flip_cfg      = 2'd0;
        rows_cfg      = 7'd50;
        width_cfg     = 8'd128;
        height_cfg    = 8'd250;
        fill_cfg      = 2'd1;
        for (int a = 0; a < PLANE_DEPTH; a++) begin
            black_mem[a] = 8'h00;
            red_mem[a]   = 8'h00;
        end

        // Scripted part. Planes are only read once a page fill has covered them.
        add_row(REQ_DRAW, -1024, -1024, 3, 0, 0, 1, 0, 0, 0);
        add_row(REQ_NONE, 1023, 1023, 3, 255, 1023, 1, 0, 0, 0);
        add_row(REQ_PAGE, 0, 0, 0, 0, 0, 1, 0, 0, 0);
        add_row(REQ_READ, 0, 0, 0, 0, 0, 1, 8'hFF, 8'h00, 0);
        add_row(REQ_DRAW, 0, 0, 0, 0, 0, 1, 0, 0, 1);
        add_row(REQ_READ, 0, 0, 0, 0, 784, 1, 8'h7F, 8'h00, 0);
        add_row(REQ_DRAW, 127, 49, 2, 0, 0, 1, 0, 0, 1);
        add_row(REQ_READ, 0, 0, 0, 0, 15, 1, 8'hFE, 8'h01, 0);
        add_row(REQ_DRAW, 128, 0, 1, 0, 0, 1, 0, 0, 0);
        add_row(REQ_DRAW, 0, 50, 1, 0, 0, 1, 0, 0, 0);
        add_cfg(CFG_PAGE_ROWS, 64);
        add_row(REQ_PAGE, 0, 0, 0, 3, 0, 1, 0, 0, 0);
        add_row(REQ_READ, 0, 0, 0, 0, 1023, 1, 8'hFF, 8'h00, 0);
        add_cfg(CFG_DEF_COLOR, 2);
        add_row(REQ_PAGE, 0, 0, 0, 255, 0, 1, 0, 0, 0);
        add_row(REQ_READ, 0, 0, 0, 0, 0, 1, 8'h00, 8'hFF, 0);
        add_cfg(CFG_PAGE_ROWS, 0);
        add_cfg(CFG_DEF_COLOR, 0);
        add_row(REQ_PAGE, 0, 0, 0, 5, 0, 1, 0, 0, 0);
        add_row(REQ_DRAW, 0, 0, 3, 0, 0, 1, 0, 0, 0);
        add_cfg(CFG_PAGE_ROWS, 127);
        add_cfg(CFG_DEF_COLOR, 3);
        add_row(REQ_PAGE, 0, 0, 0, 1, 0, 1, 0, 0, 0);
        add_row(REQ_READ, 0, 0, 0, 0, 1023, 1, 8'hFF, 8'hFF, 0);
        add_row(REQ_DRAW, 5, 64, 0, 0, 0, 0, 0, 0, 0);
        add_row(REQ_READ, 0, 0, 0, 0, 1008, 0, 0, 0, 0);
        add_cfg(CFG_DRAW_W, 200);
        add_row(REQ_DRAW, 130, 64, 0, 0, 0, 1, 0, 0, 0);
        add_row(REQ_DRAW, 130, 65, 0, 0, 0, 0, 0, 0, 0);
        add_row(REQ_READ, 0, 0, 0, 0, 1008, 0, 0, 0, 0);
        add_cfg(CFG_ROTATION, 1);
        add_cfg(CFG_FLIP_MODE, 3);
        add_cfg(CFG_DRAW_H, 255);
        add_row(REQ_DRAW, 100, 200, 1, 0, 0, 0, 0, 0, 0);
        add_row(REQ_READ, 0, 0, 0, 0, 440, 0, 0, 0, 0);

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[i]) begin
            if (script[i].is_cfg) begin
                settle();
                write_reg(script[i].cfg_idx, script[i].cfg_val);
            end else begin
                it = script[i].item;
                if (script[i].typed) begin
                    void'(plot_step(it));
                    send_item(it, script[i].res);
                end else begin
                    send_item(it, plot_step(it));
                end
            end
        end

        // Random phases. Each phase opens with a page fill; most draws are aimed
        // back through the mirror and the turn so that they land in the page.
        for (ph = 0; ph < PHASES; ph++) begin
            settle();
            calm = (ph >= 8 && ph <= 10);
            write_reg(CFG_ROTATION, 8'(ph % 4));
            write_reg(CFG_FLIP_MODE, 8'((ph / 4) % 4));
            case (ph)
                1: v = 0;
                2: v = 127;
                3: v = 1;
                4: v = 64;
                default: v = $urandom_range(64, 1);
            endcase
            write_reg(CFG_PAGE_ROWS, 8'(v));
            case (ph)
                4: v = 0;
                5: v = 255;
                6: v = 128;
                default: v = $urandom_range(255, 1);
            endcase
            write_reg(CFG_DRAW_W, 8'(v));
            case (ph)
                6: v = 0;
                7: v = 255;
                8: v = 250;
                default: v = $urandom_range(255);
            endcase
            write_reg(CFG_DRAW_H, 8'(v));
            write_reg(CFG_DEF_COLOR, 8'($urandom_range(3)));

            for (k = 0; k < PHASE_ITEMS; k++) begin
                it.color = 2'($urandom_range(3));
                it.page  = 8'($urandom);
                it.addr  = 10'($urandom);
                it.x     = 11'($urandom);
                it.y     = 11'($urandom);
                roll = (k == 0) ? 0 : $urandom_range(99);
                if (roll < 8) begin
                    it.req = REQ_PAGE;
                    if ($urandom_range(9) != 0) it.page = 8'($urandom_range(3));
                end else if (roll < 33) begin
                    it.req = REQ_READ;
                end else if (roll < 37) begin
                    it.req = REQ_NONE;
                end else begin
                    it.req = REQ_DRAW;
                    rows = eff_rows();
                    dw   = int'(width_cfg);
                    if (roll < 87 && rows > 0 && dw > 0) begin
                        qx = $urandom_range(dw - 1);
                        qy = top_row + $urandom_range(rows - 1);
                        case (rot_cfg)
                            2'd0: begin px = qx; py = qy; end
                            2'd1: begin px = qy; py = PANEL_COLS - 7 - qx; end
                            2'd2: begin px = PANEL_COLS - 7 - qx; py = PANEL_LINES - 1 - qy; end
                            default: begin px = PANEL_LINES - 1 - qy; py = qx; end
                        endcase
                        if (flip_cfg[0]) px = dw - px;
                        if (flip_cfg[1]) py = int'(height_cfg) - py;
                        if (px >= -1024 && px <= 1023 && py >= -1024 && py <= 1023) begin
                            it.x = px[10:0];
                            it.y = py[10:0];
                        end
                    end
                end
                send_item(it, plot_step(it));
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
